// ----- sv/mcfsm_pkg.sv -----
`timescale 1ns / 1ps

package mcfsm_pkg;

    // Controller states, one-hot
    typedef enum logic [10:0] {
        ST_FETCH    = 11'b000_0000_0001,
        ST_DECODE   = 11'b000_0000_0010,
        ST_ADDR     = 11'b000_0000_0100,
        ST_MEM_RD   = 11'b000_0000_1000,
        ST_LOAD_WB  = 11'b000_0001_0000,
        ST_STORE    = 11'b000_0010_0000,
        ST_ITYPE_WB = 11'b000_0100_0000,
        ST_RTYPE_EX = 11'b000_1000_0000,
        ST_RTYPE_WB = 11'b001_0000_0000,
        ST_BRANCH   = 11'b010_0000_0000,
        ST_JUMP     = 11'b100_0000_0000
    } state_t;

    // Opcodes
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // R-type function codes
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd2;
    localparam logic [2:0] FN_AND = 3'd4;
    localparam logic [2:0] FN_OR  = 3'd5;

    // ALU operation codes
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd2;

    // Next pc select
    localparam logic [1:0] PCS_ALU    = 2'd0;
    localparam logic [1:0] PCS_BRANCH = 2'd1;
    localparam logic [1:0] PCS_JUMP   = 2'd2;

    // ALU B operand select
    localparam logic [1:0] SRCB_REG   = 2'd0;
    localparam logic [1:0] SRCB_CONST = 2'd1;
    localparam logic [1:0] SRCB_IMM   = 2'd2;

    // Full set of control outputs
    typedef struct packed {
        logic [1:0] alu_src_b;
        logic       alu_src_a;
        logic [2:0] alu_control;
        logic       reg_dest;
        logic [1:0] pc_source;
        logic       pc_write;
        logic       mem_to_reg;
        logic       ir_write;
        logic       reg_write;
        logic       instr_or_data;
        logic       mem_write;
        logic       branch_enable;
    } ctrl_t;

endpackage

// ----- sv/multicycle_cpu_control_fsm_top.sv -----
`timescale 1ns / 1ps

// Control unit of a small multicycle processor.
// Each beat on the slave channel is one clock step of the processor and
// carries the current instruction's opcode and function code. The unit
// updates the control signals named by its current state, holds the rest,
// advances to the next state and sends all twelve control signals as one
// beat on the master channel.
// The result beat is registered and appears in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the receiver takes each result; the
// next-state and control logic is a single decode between the state registers and the output register.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled receiver holds the result and blocks only new input.
// Reset puts the unit in the fetch state with all control signals zero and
// empties the output register.
// Unknown opcodes keep the unit in the decode or address state.

module multicycle_cpu_control_fsm_top
    import mcfsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] opcode, [6:4] function_code, [7] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] branch_enable, [1] mem_write,
                                   // [2] instr_or_data, [3] reg_write,
                                   // [4] ir_write, [5] mem_to_reg, [6] pc_write,
                                   // [8:7] pc_source, [9] reg_dest,
                                   // [12:10] alu_control, [13] alu_src_a,
                                   // [15:14] alu_src_b
);

    state_t      state_reg;
    state_t      state_next;
    ctrl_t       ctrl_reg;
    ctrl_t       ctrl_next;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [3:0]  opcode;
    logic [2:0]  function_code;
    logic        s_accept;
    logic        op_known;

    assign opcode        = s_tdata[3:0];
    assign function_code = s_tdata[6:4];
    assign s_tready      = !m_tvalid_reg || m_tready;
    assign s_accept      = s_tvalid && s_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    assign op_known = (opcode == OP_RTYPE) || (opcode == OP_JUMP) || (opcode == OP_ADDI)
                   || (opcode == OP_BEQ) || (opcode == OP_LW) || (opcode == OP_SW);

    // Update the signals the current state names, hold the rest
    always_comb
    begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        unique case (state_reg)
            ST_FETCH:
            begin
                ctrl_next.mem_write     = 1'b0;
                ctrl_next.alu_src_a     = 1'b0;
                ctrl_next.instr_or_data = 1'b0;
                ctrl_next.ir_write      = 1'b1;
                ctrl_next.alu_src_b     = SRCB_CONST;
                ctrl_next.alu_control   = ALU_ADD;
                ctrl_next.pc_write      = 1'b1;
                ctrl_next.pc_source     = PCS_ALU;
                ctrl_next.reg_dest      = 1'b1;
                state_next              = ST_DECODE;
            end
            ST_DECODE:
            begin
                ctrl_next.alu_src_a   = 1'b0;
                ctrl_next.alu_src_b   = SRCB_IMM;
                ctrl_next.alu_control = ALU_ADD;
                ctrl_next.reg_dest    = 1'b1;
                case (opcode)
                    OP_RTYPE:
                    begin
                        case (function_code) inside
                            FN_SUB, FN_AND, FN_OR: ctrl_next.alu_control = function_code;
                            default:               ctrl_next.alu_control = ALU_ADD;
                        endcase
                        state_next = ST_RTYPE_EX;
                    end
                    OP_JUMP:              state_next = ST_JUMP;
                    OP_ADDI, OP_LW, OP_SW: state_next = ST_ADDR;
                    OP_BEQ:               state_next = ST_BRANCH;
                    default:              state_next = ST_DECODE;
                endcase
            end
            ST_ADDR:
            begin
                ctrl_next.alu_src_a   = 1'b1;
                ctrl_next.alu_src_b   = SRCB_IMM;
                ctrl_next.alu_control = ALU_ADD;
                case (opcode)
                    OP_ADDI: state_next = ST_ITYPE_WB;
                    OP_LW:   state_next = ST_MEM_RD;
                    OP_SW:   state_next = ST_STORE;
                    default: state_next = ST_ADDR;
                endcase
            end
            ST_MEM_RD:
            begin
                ctrl_next.mem_write     = 1'b0;
                ctrl_next.instr_or_data = 1'b1;
                ctrl_next.alu_src_a     = 1'b1;
                ctrl_next.alu_src_b     = SRCB_IMM;
                state_next              = ST_LOAD_WB;
            end
            ST_LOAD_WB:
            begin
                ctrl_next.reg_write  = 1'b1;
                ctrl_next.mem_to_reg = 1'b1;
                ctrl_next.reg_dest   = 1'b0;
                ctrl_next.alu_src_a  = 1'b1;
                ctrl_next.alu_src_b  = SRCB_IMM;
                state_next           = ST_FETCH;
            end
            ST_STORE:
            begin
                ctrl_next.mem_write     = 1'b1;
                ctrl_next.instr_or_data = 1'b1;
                ctrl_next.alu_src_a     = 1'b1;
                ctrl_next.alu_src_b     = SRCB_IMM;
                state_next              = ST_FETCH;
            end
            ST_ITYPE_WB:
            begin
                ctrl_next.mem_write  = 1'b0;
                ctrl_next.reg_write  = 1'b1;
                ctrl_next.reg_dest   = 1'b0;
                ctrl_next.mem_to_reg = 1'b0;
                ctrl_next.alu_src_a  = 1'b1;
                ctrl_next.alu_src_b  = SRCB_IMM;
                state_next           = ST_FETCH;
            end
            ST_RTYPE_EX:
            begin
                ctrl_next.alu_src_a = 1'b1;
                ctrl_next.alu_src_b = SRCB_REG;
                ctrl_next.reg_dest  = 1'b1;
                state_next          = ST_RTYPE_WB;
            end
            ST_RTYPE_WB:
            begin
                ctrl_next.reg_dest   = 1'b1;
                ctrl_next.reg_write  = 1'b1;
                ctrl_next.mem_to_reg = 1'b0;
                state_next           = ST_FETCH;
            end
            ST_BRANCH:
            begin
                ctrl_next.alu_src_a     = 1'b1;
                ctrl_next.alu_src_b     = SRCB_IMM;
                ctrl_next.alu_control   = ALU_SUB;
                ctrl_next.branch_enable = 1'b1;
                ctrl_next.pc_write      = 1'b0;
                ctrl_next.pc_source     = PCS_BRANCH;
                state_next              = ST_FETCH;
            end
            ST_JUMP:
            begin
                ctrl_next.pc_write  = 1'b1;
                ctrl_next.pc_source = PCS_JUMP;
                state_next          = ST_FETCH;
            end
            default:
            begin
                state_next = state_reg;
                ctrl_next  = ctrl_reg;
            end
        endcase
    end

    // Advance the state and held signals on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FETCH;
            ctrl_reg  <= '0;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Output beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_tdata_reg <= ctrl_next;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_fetch_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && state_reg == ST_FETCH) |=> (state_reg == ST_DECODE && ctrl_reg.ir_write))
        else $error("fetch did not advance to decode");

    a_decode_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && state_reg == ST_DECODE && !op_known) |=> (state_reg == ST_DECODE))
        else $error("unknown opcode left decode");

    a_branch_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && state_reg == ST_BRANCH)
            |=> (ctrl_reg.branch_enable && !ctrl_reg.pc_write
                 && ctrl_reg.pc_source == PCS_BRANCH && state_reg == ST_FETCH))
        else $error("branch state set wrong controls");

    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (m_tdata_reg == ctrl_reg))
        else $error("result beat differs from held controls");
`endif

endmodule
